FILE: design/tli_pkg.sv
`default_nettype none
package tli_pkg;
  localparam logic [2:0] FN_WRITE  = 3'd0;
  localparam logic [2:0] FN_ROTATE = 3'd1;
  localparam logic [2:0] FN_TIMES  = 3'd2;
  localparam logic [2:0] FN_TARGET = 3'd3;
  localparam logic [2:0] FN_READ   = 3'd4;

  localparam logic [1:0] MODE_LINEAR   = 2'd0;
  localparam logic [1:0] MODE_CYCLICAL = 2'd1;
  localparam logic [1:0] MODE_SEASONAL = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_NO_TARGET = 2'd3;

  localparam int TIME_W  = 40;
  localparam int VALUE_W = 32;
  localparam int ALPHA_W = 24;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;
  // 366.0 and 1.0 in Q24.16
  localparam logic signed [TIME_W+1:0] DOY_MAX = 42'sd23986176;
  localparam logic signed [TIME_W+1:0] Q16_ONE = 42'sd65536;

  typedef struct packed {
    logic                   start;
    logic [TIME_W:0]        num;
    logic [TIME_W:0]        den;
  } tli_div_req_t;
endpackage
`default_nettype wire

FILE: design/tli_divider.sv
`default_nettype none
module tli_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tli_pkg::tli_div_req_t         req,
  output logic                               busy,
  output logic                               done,
  output logic [tli_pkg::ALPHA_W-1:0]        alpha
);
  import tli_pkg::*;
  // restoring division of num*2^16 by den, one quotient bit a cycle
  localparam int QW = TIME_W + 1 + 16;
  localparam int CW = $clog2(QW + 1);

  logic [QW-1:0]    dividend_r, dividend_nxt;
  logic [TIME_W+1:0] rem_r, rem_nxt;
  logic [TIME_W:0]  den_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt, done_r;
  logic [TIME_W+1:0] trial;

  always_comb begin
    trial = {rem_r[TIME_W:0], dividend_r[QW-1]} - {1'b0, den_r};
    dividend_nxt = dividend_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.start) begin
      dividend_nxt = {req.num, 16'd0};
      rem_nxt = '0;
      cnt_nxt = CW'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[TIME_W+1]) begin
        rem_nxt = trial;
        dividend_nxt = {dividend_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[TIME_W:0], dividend_r[QW-1]};
        dividend_nxt = {dividend_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= busy_r && (cnt_r == CW'(1));
      cnt_r  <= cnt_nxt;
    end
    dividend_r <= dividend_nxt;
    rem_r      <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign alpha = (|dividend_r[QW-1:ALPHA_W]) ? ALPHA_MAX : dividend_r[ALPHA_W-1:0];

  property p_done_after_busy;
    @(posedge clk) disable iff (!rst_n) done |-> $past(busy_r);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_no_start_busy;
    @(posedge clk) disable iff (!rst_n) busy_r |-> !req.start;
  endproperty
  a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

  property p_done_idle;
    @(posedge clk) disable iff (!rst_n) done |-> !busy_r;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("done while busy");
endmodule
`default_nettype wire

FILE: design/two_level_temporal_interpolator.sv
`default_nettype none
// two-level temporal interpolator
// input channel in_valid/in_ready carries one command per transfer: write an
// element to the next slot, rotate slots, load bracket times, set a target
// time, or read one interpolated element. every transfer yields exactly one
// result transfer on out_valid/out_ready (status and result_value).
// cfg_we/cfg_interp_mode loads the mode register; the user must load it only
// while idle, the block does not enforce this. writes, rotates, time loads,
// odd codes and a set target that needs no division answer in the cycle after
// the transfer; reads go through memory read, difference, multiply, and add
// and saturate; a set target that divides answers once the bit-serial divider
// has formed its 57 quotient bits. one item is in flight at a time, so the
// next input transfer can come in the cycle after the result transfer; a
// stalled receiver holds the result in the output register and the input is
// not taken until it drains.
// reset clears slot select, bracket times, weight, mode and sets the held
// status to no target; slot memories are not cleared.
module two_level_temporal_interpolator #(
  parameter int ELEMENTS = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [1:0]         cfg_interp_mode,
  input  wire logic               cfg_we,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_func,
  input  wire logic [11:0]        in_index,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic signed [39:0] in_time_prev,
  input  wire logic signed [39:0] in_time_next,
  input  wire logic signed [39:0] in_target_time,
  input  wire logic               in_have_file_times,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [31:0]      out_result_value
);
  import tli_pkg::*;
  // the index is 12 bits wide, so no more than 4096 entries are addressable
  localparam int DEPTH = (ELEMENTS > 4096) ? 4096 : ELEMENTS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // phase codes
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_RD   = 3'd1;
  localparam logic [2:0] PH_MUL  = 3'd2;
  localparam logic [2:0] PH_ADD  = 3'd3;
  localparam logic [2:0] PH_DIV  = 3'd4;
  localparam logic [2:0] PH_OUT  = 3'd5;

  logic [VALUE_W-1:0] mem0 [DEPTH];
  logic [VALUE_W-1:0] mem1 [DEPTH];
  logic [VALUE_W-1:0] rd0_r, rd1_r;

  logic [2:0]  ph_r;
  logic [1:0]  mode_r;
  logic        sel_r;
  logic signed [TIME_W-1:0] bp_r, bn_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [1:0]  tstat_r;
  logic        rd_ok_r;
  logic signed [VALUE_W:0] pv_r, diff_r;
  logic [VALUE_W+ALPHA_W-1:0] prod_r;
  logic        neg_r;
  logic [1:0]  ostat_r;
  logic signed [VALUE_W-1:0] oval_r;
  logic        ovalid_r;

  logic        acc;
  logic        in_range;
  assign in_ready = (ph_r == PH_IDLE) && !ovalid_r;
  assign acc = in_valid && in_ready;
  assign in_range = (13'(in_index) < 13'(DEPTH));

  // target evaluation
  logic signed [TIME_W+1:0] t, p, n, ival, ofs;
  logic [1:0] tst;
  logic       need_div;
  tli_div_req_t dreq;
  logic dbusy, ddone;
  logic [ALPHA_W-1:0] dalpha;

  always_comb begin
    t = {{2{in_target_time[TIME_W-1]}}, in_target_time};
    p = {{2{bp_r[TIME_W-1]}}, bp_r};
    n = {{2{bn_r[TIME_W-1]}}, bn_r};
    ival = n - p;
    ofs  = t - p;
    tst = ST_OK;
    need_div = 1'b0;
    if (p != n) begin
      if (mode_r == MODE_CYCLICAL) begin
        if (t < Q16_ONE || t > DOY_MAX) tst = ST_RANGE;
        else begin
          if (ival < 0) ival = ival + DOY_MAX;
          if (ofs < 0) ofs = ofs + DOY_MAX;
          need_div = (ofs > 0) && (ival > 0);
        end
      end else if (mode_r == MODE_SEASONAL && !in_have_file_times) begin
        tst = ST_EXHAUSTED;
      end else if (t < p || t > n) begin
        tst = ST_RANGE;
      end else begin
        need_div = ofs > 0;
      end
    end
    dreq.start = acc && (in_func == FN_TARGET) && need_div && (tst == ST_OK);
    dreq.num   = ofs[TIME_W:0];
    dreq.den   = ival[TIME_W:0];
  end

  tli_divider u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq),
    .busy(dbusy), .done(ddone), .alpha(dalpha)
  );

  // interpolation term and its sum, saturated in the add phase
  logic [VALUE_W:0] mag;
  logic signed [VALUE_W+ALPHA_W:0] term, sum;
  always_comb begin
    mag = diff_r[VALUE_W] ? (VALUE_W+1)'(-diff_r) : (VALUE_W+1)'(diff_r);
    term = $signed({1'b0, prod_r >> 16});
    sum = neg_r ? ({{ALPHA_W{pv_r[VALUE_W]}}, pv_r} - term)
                : ({{ALPHA_W{pv_r[VALUE_W]}}, pv_r} + term);
  end

  always_ff @(posedge clk) begin
    if (acc && in_func == FN_WRITE && in_range) begin
      if (sel_r) mem1[in_index[AW-1:0]] <= in_sample_value;
      else       mem0[in_index[AW-1:0]] <= in_sample_value;
    end
    rd0_r <= mem0[in_index[AW-1:0]];
    rd1_r <= mem1[in_index[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
      mode_r <= MODE_LINEAR;
      sel_r <= 1'b0;
      bp_r <= '0;
      bn_r <= '0;
      alpha_r <= '0;
      tstat_r <= ST_NO_TARGET;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_we) mode_r <= cfg_interp_mode;
      if (out_valid && out_ready) ovalid_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: begin
          if (acc) begin
            // set target answers its new status, a read the held one
            ostat_r <= (in_func == FN_TARGET) ? tst :
                       (in_func == FN_READ) ? tstat_r : ST_OK;
            oval_r <= '0;
            case (in_func)
              FN_WRITE: ovalid_r <= 1'b1;
              FN_ROTATE: begin
                sel_r <= ~sel_r;
                ovalid_r <= 1'b1;
              end
              FN_TIMES: begin
                bp_r <= in_time_prev;
                bn_r <= in_time_next;
                ovalid_r <= 1'b1;
              end
              FN_TARGET: begin
                alpha_r <= '0;
                tstat_r <= tst;
                if (dreq.start) ph_r <= PH_DIV;
                else ovalid_r <= 1'b1;
              end
              FN_READ: begin
                rd_ok_r <= (tstat_r == ST_OK) && in_range;
                ph_r <= PH_RD;
              end
              default: ovalid_r <= 1'b1;
            endcase
          end
        end
        PH_RD: begin
          pv_r <= sel_r ? {rd0_r[VALUE_W-1], rd0_r} : {rd1_r[VALUE_W-1], rd1_r};
          diff_r <= sel_r ? ($signed({rd1_r[VALUE_W-1], rd1_r}) - $signed({rd0_r[VALUE_W-1], rd0_r}))
                          : ($signed({rd0_r[VALUE_W-1], rd0_r}) - $signed({rd1_r[VALUE_W-1], rd1_r}));
          ph_r <= PH_MUL;
        end
        PH_MUL: begin
          neg_r <= diff_r[VALUE_W];
          prod_r <= mag * alpha_r;
          ph_r <= PH_ADD;
        end
        PH_ADD: begin
          if (!rd_ok_r) oval_r <= '0;
          else if (sum > $signed({{(ALPHA_W+1){1'b0}}, 32'h7FFFFFFF}))
            oval_r <= 32'sh7FFFFFFF;
          else if (sum < $signed({{(ALPHA_W+1){1'b1}}, 32'h80000000}))
            oval_r <= 32'sh80000000;
          else oval_r <= sum[VALUE_W-1:0];
          ovalid_r <= 1'b1;
          ph_r <= PH_IDLE;
        end
        PH_DIV: begin
          if (ddone) begin
            alpha_r <= dalpha;
            ovalid_r <= 1'b1;
            ph_r <= PH_IDLE;
          end
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign out_valid = ovalid_r;
  assign out_status = ostat_r;
  assign out_result_value = oval_r;

  property p_one_in_flight;
    @(posedge clk) disable iff (!rst_n) acc |=> !in_ready;
  endproperty
  a_one_in_flight: assert property (p_one_in_flight) else $error("second item taken");

  property p_div_phase;
    @(posedge clk) disable iff (!rst_n) dbusy |-> (ph_r == PH_DIV);
  endproperty
  a_div_phase: assert property (p_div_phase) else $error("divider busy outside wait");

  property p_read_status;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_status != ST_OK) |-> (out_result_value == 0);
  endproperty
  a_read_status: assert property (p_read_status) else $error("nonzero result on error");
endmodule
`default_nettype wire
